[src/grkv_pkg.sv]
// types and constants shared by the gated ring key/value store
`default_nettype none

package grkv_pkg;

    // operation codes of an input item
    typedef enum logic [1:0] {
        OP_WRITE   = 2'd0,
        OP_READ    = 2'd1,
        OP_ADVANCE = 2'd2,
        OP_CLEAR   = 2'd3
    } grkv_op_t;

    // reset value of the head size register
    localparam logic [6:0] HEAD_SIZE_RESET = 7'd64;
    // gate value that keeps the new element fully
    localparam logic [8:0] GATE_ONE = 9'd256;
    // number of codes of the token offset and token count fields
    localparam int OFFSET_CODES = 64;
    localparam int COUNT_CODES  = 128;

    // one input item
    typedef struct packed {
        logic [1:0]         operation;
        logic [2:0]         head;
        logic [5:0]         token_offset;
        logic [6:0]         read_slot;
        logic [5:0]         element;
        logic signed [15:0] new_key;
        logic signed [15:0] new_value;
        logic [8:0]         gate;
        logic [6:0]         token_count;
    } grkv_in_t;

    // one result item
    typedef struct packed {
        logic signed [15:0] key_out;
        logic signed [15:0] value_out;
        logic [6:0]         history_length;
    } grkv_out_t;

    // decoded request handed to the read-modify-write stage
    typedef struct packed {
        logic               valid;
        logic               wr;
        logic               rd;
        logic [8:0]         gate;
        logic signed [15:0] new_key;
        logic signed [15:0] new_value;
        logic [6:0]         history_length;
    } grkv_req_t;

endpackage

`default_nettype wire

[src/grkv_rmw.sv]
// element memory with read-modify-write blend, write forwarding and result register
`default_nettype none

module grkv_rmw #(
    parameter int AW = 15
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire grkv_pkg::grkv_req_t req,
    input  wire logic [AW-1:0]      req_addr,
    input  wire logic               wipe_en,
    input  wire logic [AW-1:0]      wipe_addr,
    output logic                    done,
    output grkv_pkg::grkv_out_t     result
);
    import grkv_pkg::*;

    localparam int DEPTH = 2 ** AW;

    // key in the upper half, value in the lower half
    logic [31:0]        mem_ram [0:DEPTH-1];
    logic [31:0]        rd_data_reg;

    logic               st_valid_reg;
    grkv_req_t          st_req_reg;
    logic [AW-1:0]      st_addr_reg;

    logic               fwd_valid_reg;
    logic [AW-1:0]      fwd_addr_reg;
    logic [31:0]        fwd_data_reg;

    logic               done_reg;
    grkv_out_t          result_reg;
    grkv_out_t          result_next;

    logic [31:0]        old_data;
    logic signed [15:0] old_key;
    logic signed [15:0] old_value;
    logic signed [15:0] blend_key;
    logic signed [15:0] blend_value;
    logic               wr_en;
    logic               mem_we;
    logic [AW-1:0]      mem_waddr;
    logic [31:0]        mem_wdata;

    // old + floor(g * (new - old) / 256), exact for gate 0..256
    function automatic logic signed [15:0] blend(
        input logic signed [15:0] nv,
        input logic signed [15:0] old,
        input logic [8:0]         g
    );
        logic signed [16:0] diff;
        logic signed [26:0] prod;
        logic [18:0]        sum;
        diff = {nv[15], nv} - {old[15], old};
        prod = $signed({1'b0, g}) * diff;
        sum  = {{3{old[15]}}, old} + prod[26:8];
        return sum[15:0];
    endfunction

    // memory: write port and registered read port, read returns old data
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem_ram[mem_waddr] <= mem_wdata;
        end
        if (req.valid)
        begin
            rd_data_reg <= mem_ram[req_addr];
        end
    end

    // stage control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_valid_reg  <= 1'b0;
            fwd_valid_reg <= 1'b0;
            done_reg      <= 1'b0;
        end
        else
        begin
            st_valid_reg  <= req.valid;
            fwd_valid_reg <= wr_en;
            done_reg      <= st_valid_reg;
        end
    end

    // stage payload
    always_ff @(posedge clk)
    begin
        if (req.valid)
        begin
            st_req_reg  <= req;
            st_addr_reg <= req_addr;
        end
        if (wr_en)
        begin
            fwd_addr_reg <= st_addr_reg;
            fwd_data_reg <= {blend_key, blend_value};
        end
        if (st_valid_reg)
        begin
            result_reg <= result_next;
        end
    end

    // forward the write that landed at the same edge as this read
    always_comb
    begin
        if (fwd_valid_reg && (fwd_addr_reg == st_addr_reg))
        begin
            old_data = fwd_data_reg;
        end
        else
        begin
            old_data = rd_data_reg;
        end
    end

    assign old_key     = old_data[31:16];
    assign old_value   = old_data[15:0];
    assign blend_key   = blend(st_req_reg.new_key, old_key, st_req_reg.gate);
    assign blend_value = blend(st_req_reg.new_value, old_value, st_req_reg.gate);
    assign wr_en       = st_valid_reg && st_req_reg.wr;

    // write port: reset sweep has the port to itself
    always_comb
    begin
        if (wipe_en)
        begin
            mem_we    = 1'b1;
            mem_waddr = wipe_addr;
            mem_wdata = '0;
        end
        else
        begin
            mem_we    = wr_en;
            mem_waddr = st_addr_reg;
            mem_wdata = {blend_key, blend_value};
        end
    end

    // result fields, zero padding except for a read in range
    always_comb
    begin
        result_next.history_length = st_req_reg.history_length;
        if (st_req_reg.rd)
        begin
            result_next.key_out   = old_key;
            result_next.value_out = old_value;
        end
        else
        begin
            result_next.key_out   = '0;
            result_next.value_out = '0;
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

`default_nettype wire

[src/gated_ring_kv_store.sv]
// top level of the gated ring key/value store
`default_nettype none

// Per-head key/value ring store, one vector element per command.
// Commands: write element (gated blend into slot pointer + offset), read
// element, advance history by a token count, clear history.
// Command channel: an item transfers at a rising edge with start high and
// busy low. Each command gives one result on result, marked by done for
// exactly one cycle; it passes the stage register and the result register,
// and the receiver cannot stall, so results are never held back.
// Throughput is one command per cycle while busy is low: the element memory
// does one read and one write per cycle, and a write that lands while the next
// command reads the same element is forwarded into that command's blend or readout.
// head_size is written through cfg_we/cfg_data at any edge, no wait.
// Reset clears the pointer, the fill count and head_size (to 64), then a
// sweep zeroes the element memory one entry per cycle: busy stays high until
// all 2**(HW+PW+EW) entries (32768 at default parameters) are zeroed, where
// HW, PW and EW are the address bits of head, history slot and element.
module gated_ring_kv_store #(
    parameter int HISTORY_SLOTS = 64,
    parameter int NUM_HEADS     = 8,
    parameter int MAX_HEAD_SIZE = 64
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    output logic                     busy,
    input  wire grkv_pkg::grkv_in_t  item,
    output logic                     done,
    output grkv_pkg::grkv_out_t      result,
    input  wire logic                cfg_we,
    input  wire logic [6:0]          cfg_data
);
    import grkv_pkg::*;

    localparam int PW = $clog2(HISTORY_SLOTS);
    localparam int HW = (NUM_HEADS > 1) ? $clog2(NUM_HEADS) : 1;
    localparam int EW = (MAX_HEAD_SIZE > 1) ? $clog2(MAX_HEAD_SIZE) : 1;
    localparam int AW = HW + PW + EW;
    localparam int FW = $clog2(HISTORY_SLOTS + 1);
    localparam int SW = ((FW > 7) ? FW : 7) + 1;

    logic [6:0]    head_size_reg;
    logic [PW-1:0] wp_reg;
    logic [PW-1:0] wp_next;
    logic [FW-1:0] fill_reg;
    logic [FW-1:0] fill_next;
    logic          wipe_active_reg;
    logic [AW-1:0] wipe_addr_reg;

    logic [PW-1:0] off_mod [OFFSET_CODES];
    logic [PW-1:0] cnt_mod [COUNT_CODES];

    logic          accept;
    logic          head_ok;
    logic          elem_ok;
    logic          slot_ok;
    logic [8:0]    active_size;
    logic [PW-1:0] write_slot;
    logic [SW-1:0] fill_sum;
    logic [AW-1:0] write_addr;
    logic [AW-1:0] read_addr;
    logic [AW-1:0] req_addr;
    grkv_req_t     req;

    // (a + b) mod slots for a, b below slots
    function automatic logic [PW-1:0] wrap_add(
        input logic [PW-1:0] a,
        input logic [PW-1:0] b
    );
        logic [PW:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        if (sum >= (PW+1)'(HISTORY_SLOTS))
        begin
            sum = sum - (PW+1)'(HISTORY_SLOTS);
        end
        return sum[PW-1:0];
    endfunction

    // constant tables of offset and count modulo the ring length
    for (genvar i = 0; i < OFFSET_CODES; i++)
    begin : g_off_mod
        assign off_mod[i] = PW'(i % HISTORY_SLOTS);
    end
    for (genvar i = 0; i < COUNT_CODES; i++)
    begin : g_cnt_mod
        assign cnt_mod[i] = PW'(i % HISTORY_SLOTS);
    end

    assign busy   = wipe_active_reg;
    assign accept = start && !busy;

    // addressing checks
    assign active_size = (9'(head_size_reg) > 9'(MAX_HEAD_SIZE)) ?
                         9'(MAX_HEAD_SIZE) : 9'(head_size_reg);
    assign head_ok     = 7'(item.head) < 7'(NUM_HEADS);
    assign elem_ok     = 9'(item.element) < active_size;
    assign slot_ok     = (SW'(item.read_slot) < SW'(fill_reg)) &&
                         (SW'(item.read_slot) < SW'(HISTORY_SLOTS));

    // element addresses: head, slot, element
    assign write_slot = wrap_add(wp_reg, off_mod[item.token_offset]);
    assign write_addr = {HW'(item.head), write_slot, EW'(item.element)};
    assign read_addr  = {HW'(item.head), PW'(item.read_slot), EW'(item.element)};

    assign fill_sum = SW'(fill_reg) + SW'(item.token_count);

    // command decode and history state update
    always_comb
    begin
        wp_next   = wp_reg;
        fill_next = fill_reg;
        req_addr  = read_addr;
        req.wr    = 1'b0;
        req.rd    = 1'b0;
        unique case (item.operation)
            OP_WRITE:
            begin
                req.wr   = head_ok && elem_ok;
                req_addr = write_addr;
            end
            OP_READ:
            begin
                req.rd = head_ok && elem_ok && slot_ok;
            end
            OP_ADVANCE:
            begin
                wp_next = wrap_add(wp_reg, cnt_mod[item.token_count]);
                if (fill_sum > SW'(HISTORY_SLOTS))
                begin
                    fill_next = FW'(HISTORY_SLOTS);
                end
                else
                begin
                    fill_next = fill_sum[FW-1:0];
                end
            end
            OP_CLEAR:
            begin
                fill_next = '0;
            end
            default:
            begin
                fill_next = fill_reg;
            end
        endcase
        req.valid          = accept;
        req.gate           = (item.gate > GATE_ONE) ? GATE_ONE : item.gate;
        req.new_key        = item.new_key;
        req.new_value      = item.new_value;
        req.history_length = 7'(fill_next);
    end

    // history state and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_size_reg <= HEAD_SIZE_RESET;
            wp_reg        <= '0;
            fill_reg      <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                head_size_reg <= cfg_data;
            end
            if (accept)
            begin
                wp_reg   <= wp_next;
                fill_reg <= fill_next;
            end
        end
    end

    // memory zeroing sweep after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wipe_active_reg <= 1'b1;
            wipe_addr_reg   <= '0;
        end
        else if (wipe_active_reg)
        begin
            wipe_addr_reg <= wipe_addr_reg + 1'b1;
            if (wipe_addr_reg == {AW{1'b1}})
            begin
                wipe_active_reg <= 1'b0;
            end
        end
    end

    grkv_rmw #(
        .AW (AW)
    ) u_rmw (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .req_addr  (req_addr),
        .wipe_en   (wipe_active_reg),
        .wipe_addr (wipe_addr_reg),
        .done      (done),
        .result    (result)
    );

`ifndef SYNTHESIS
    // every transfer is followed by its result
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##2 done)
        else $error("missing result after command transfer");

    // no result without a matching earlier transfer
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(accept, 2))
        else $error("result without command transfer");

    // fill count never passes the ring length
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        SW'(fill_reg) <= SW'(HISTORY_SLOTS))
        else $error("fill count beyond ring length");

    // no result while the memory sweep runs
    a_quiet_wipe: assert property (@(posedge clk) disable iff (!rst_n)
        wipe_active_reg |-> !done)
        else $error("result during memory sweep");
`endif

endmodule

`default_nettype wire

[test/gated_ring_kv_store_tb.sv]
// self-checking testbench for the gated ring key/value store
`timescale 1ns / 100ps

module gated_ring_kv_store_tb;

    import grkv_pkg::*;

    localparam int unsigned SLOTS         = 64;
    localparam int unsigned HEADS         = 8;
    localparam int unsigned MAX_HEAD      = 64;
    localparam int unsigned STORE_ENTRIES = HEADS * SLOTS * MAX_HEAD;
    // the clearing sweep after reset holds busy until every store entry is zeroed
    localparam int unsigned STALL_LIMIT   = 4 * STORE_ENTRIES + 1000;

    typedef struct {
        grkv_in_t cmd;
        bit       drain_first;
    } pending_cmd_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       start = 1'b0;
    logic       busy;
    grkv_in_t   item = '0;
    logic       done;
    grkv_out_t  result;
    logic       cfg_we = 1'b0;
    logic [6:0] cfg_data = '0;

    // commands waiting for the driver, and readouts the store owes us
    pending_cmd_t kv_commands_pending[$];
    grkv_out_t    kv_results_due[$];

    int unsigned commands_queued = 0;
    int unsigned commands_accepted = 0;
    int unsigned errors = 0;
    int unsigned stall_cycles = 0;
    int unsigned sender_idle_pct = 29;
    bit          item_taken = 1'b0;

    // generator view of the pointer and head size, used to aim commands
    int unsigned gen_pointer = 0;
    int unsigned gen_head_size = HEAD_SIZE_RESET;

    // predicted contents of the store
    logic signed [15:0] kv_keys [STORE_ENTRIES];
    logic signed [15:0] kv_values [STORE_ENTRIES];
    int unsigned        model_fill;
    int unsigned        model_pointer;
    logic [6:0]         model_head_size;

    gated_ring_kv_store #(
        .HISTORY_SLOTS(SLOTS),
        .NUM_HEADS    (HEADS),
        .MAX_HEAD_SIZE(MAX_HEAD)
    ) DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .item    (item),
        .done    (done),
        .result  (result),
        .cfg_we  (cfg_we),
        .cfg_data(cfg_data)
    );

    // clock
    initial
    begin
        forever #5 clk = ~clk;
    end

    // gated blend of a new element into the held one, floor of the q16.8 mix
    function automatic logic signed [15:0] blend_q88(logic signed [15:0] fresh,
                                                     logic signed [15:0] held,
                                                     int unsigned g);
        int mix;
        mix = int'(g) * int'(fresh) + (256 - int'(g)) * int'(held);
        return 16'(mix >>> 8);
    endfunction

    // apply one command to the predicted store and return its readout
    function automatic grkv_out_t model_kv_command(grkv_in_t cmd);
        grkv_out_t   res;
        int unsigned active;
        int unsigned g;
        int unsigned slot;
        int unsigned idx;
        bit          reachable;
        res = '0;
        active = (model_head_size > MAX_HEAD) ? MAX_HEAD : model_head_size;
        reachable = (cmd.head < HEADS) && (cmd.element < active);
        g = (cmd.gate > GATE_ONE) ? GATE_ONE : cmd.gate;
        case (cmd.operation)
            OP_WRITE:
            begin
                if (reachable)
                begin
                    slot = (model_pointer + cmd.token_offset) % SLOTS;
                    idx = (cmd.head * SLOTS + slot) * MAX_HEAD + cmd.element;
                    kv_keys[idx] = blend_q88(cmd.new_key, kv_keys[idx], g);
                    kv_values[idx] = blend_q88(cmd.new_value, kv_values[idx], g);
                end
            end
            OP_READ:
            begin
                if (reachable && cmd.read_slot < model_fill && cmd.read_slot < SLOTS)
                begin
                    idx = (cmd.head * SLOTS + cmd.read_slot) * MAX_HEAD + cmd.element;
                    res.key_out = kv_keys[idx];
                    res.value_out = kv_values[idx];
                end
            end
            OP_ADVANCE:
            begin
                model_pointer = (model_pointer + cmd.token_count) % SLOTS;
                model_fill = model_fill + cmd.token_count;
                if (model_fill > SLOTS)
                    model_fill = SLOTS;
            end
            OP_CLEAR:
            begin
                model_fill = 0;
            end
        endcase
        res.history_length = 7'(model_fill);
        return res;
    endfunction

    // element index, mostly inside the active head size
    function automatic logic [5:0] pick_element();
        int unsigned eff;
        eff = (gen_head_size > MAX_HEAD) ? MAX_HEAD : gen_head_size;
        if ($urandom_range(9) == 0)
            return 6'($urandom_range(63));
        if (eff < MAX_HEAD && $urandom_range(9) == 0)
            return 6'(eff);
        if (eff == 0)
            return '0;
        return 6'($urandom_range(eff > 4 ? 3 : eff - 1));
    endfunction

    // fully random command with shaped operation, head, gate and counts
    function automatic grkv_in_t random_command();
        logic [95:0] noise;
        grkv_in_t    cmd;
        int unsigned roll;
        noise = {$urandom, $urandom, $urandom};
        cmd = noise[$bits(grkv_in_t)-1:0];
        roll = $urandom_range(9);
        if (roll < 3)
            cmd.operation = OP_WRITE;
        else if (roll < 7)
            cmd.operation = OP_READ;
        else if (roll < 9)
            cmd.operation = OP_ADVANCE;
        else
            cmd.operation = OP_CLEAR;
        if ($urandom_range(9) < 8)
            cmd.head = 3'($urandom_range(1));
        cmd.element = pick_element();
        case ($urandom_range(7))
            0: cmd.gate = '0;
            1: cmd.gate = GATE_ONE;
            2: cmd.gate = 9'($urandom_range(511, 257));
            default: cmd.gate = 9'($urandom_range(256));
        endcase
        roll = $urandom_range(19);
        if (roll < 17)
            cmd.token_count = 7'($urandom_range(8));
        else if (roll == 17)
            cmd.token_count = 7'(SLOTS);
        if ($urandom_range(3) != 0)
            cmd.read_slot = 7'($urandom_range(SLOTS - 1));
        return cmd;
    endfunction

    function automatic grkv_in_t make_command(grkv_op_t op, int head, int offset, int slot,
                                              int elem, int key, int val, int gate,
                                              int count);
        grkv_in_t cmd;
        cmd.operation = op;
        cmd.head = 3'(head);
        cmd.token_offset = 6'(offset);
        cmd.read_slot = 7'(slot);
        cmd.element = 6'(elem);
        cmd.new_key = 16'(key);
        cmd.new_value = 16'(val);
        cmd.gate = 9'(gate);
        cmd.token_count = 7'(count);
        return cmd;
    endfunction

    task automatic push_command(grkv_in_t cmd, bit drain_first);
        pending_cmd_t entry;
        entry.cmd = cmd;
        entry.drain_first = drain_first;
        kv_commands_pending.push_back(entry);
        commands_queued++;
        if (cmd.operation == OP_ADVANCE)
            gen_pointer = (gen_pointer + cmd.token_count) % SLOTS;
    endtask

    // token batches (write, advance, read back) mixed with loose commands
    task automatic queue_random_commands(int unsigned count);
        int unsigned added;
        int unsigned tokens;
        int unsigned base;
        logic [2:0]  h;
        logic [5:0]  e;
        grkv_in_t    cmd;
        added = 0;
        while (added < count)
        begin
            if ($urandom_range(3) == 0)
            begin
                push_command(random_command(), 1'b0);
                added++;
            end
            else
            begin
                h = ($urandom_range(9) < 8) ? 3'($urandom_range(1)) : 3'($urandom_range(7));
                e = pick_element();
                tokens = $urandom_range(4, 1);
                base = gen_pointer;
                if ($urandom_range(29) == 0)
                begin
                    cmd = random_command();
                    cmd.operation = OP_CLEAR;
                    push_command(cmd, 1'b0);
                    added++;
                end
                // write the batch, sometimes twice into one slot to blend
                for (int unsigned t = 0; t < tokens; t++)
                begin
                    cmd = random_command();
                    cmd.operation = OP_WRITE;
                    cmd.head = h;
                    cmd.element = e;
                    cmd.token_offset = 6'(t);
                    push_command(cmd, t == 0 && $urandom_range(39) == 0);
                    added++;
                    if ($urandom_range(4) == 0)
                    begin
                        cmd.new_key = 16'($urandom);
                        cmd.new_value = 16'($urandom);
                        cmd.gate = 9'($urandom_range(256));
                        push_command(cmd, 1'b0);
                        added++;
                    end
                end
                cmd = random_command();
                cmd.operation = OP_ADVANCE;
                cmd.token_count = 7'(tokens);
                push_command(cmd, 1'b0);
                added++;
                // read the batch back
                for (int unsigned t = 0; t < tokens; t++)
                begin
                    cmd = random_command();
                    cmd.operation = OP_READ;
                    cmd.head = h;
                    cmd.read_slot = 7'((base + t) % SLOTS);
                    if ($urandom_range(9) < 7)
                        cmd.element = e;
                    push_command(cmd, 1'b0);
                    added++;
                end
            end
        end
    endtask

    task automatic wait_until_drained();
        do
            @(negedge clk);
        while (commands_accepted != commands_queued || kv_results_due.size() != 0);
    endtask

    // idle store: write head_size, then queue the next batch of commands
    task automatic next_phase(logic [6:0] head_size, int unsigned idle_pct,
                              int unsigned count);
        wait_until_drained();
        cfg_we <= 1'b1;
        cfg_data <= head_size;
        @(negedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        gen_head_size = head_size;
        sender_idle_pct = idle_pct;
        queue_random_commands(count);
    endtask

    // driver: present the next command, hold it until its transfer
    always @(negedge clk)
    begin
        pending_cmd_t next_cmd;
        if (rst_n && (!start || item_taken))
        begin
            item_taken = 1'b0;
            if (kv_commands_pending.size() != 0
                && (!kv_commands_pending[0].drain_first || kv_results_due.size() == 0)
                && $urandom_range(99) >= sender_idle_pct)
            begin
                next_cmd = kv_commands_pending.pop_front();
                item <= next_cmd.cmd;
                start <= 1'b1;
            end
            else
            begin
                start <= 1'b0;
            end
        end
    end

    // monitor: check readouts, then predict each command transfer
    always @(posedge clk)
    begin
        grkv_out_t due;
        if (!rst_n)
        begin
            foreach (kv_keys[i])
            begin
                kv_keys[i] = '0;
                kv_values[i] = '0;
            end
            model_fill = 0;
            model_pointer = 0;
            model_head_size = HEAD_SIZE_RESET;
        end
        else
        begin
            if (cfg_we)
                model_head_size = cfg_data;
            if (done)
            begin
                if (kv_results_due.size() == 0)
                begin
                    $error("readout with none expected: key_out %0d value_out %0d",
                           result.key_out, result.value_out);
                    errors++;
                end
                else
                begin
                    due = kv_results_due.pop_front();
                    if (result.key_out !== due.key_out)
                    begin
                        $error("key_out: expected %0d, actual %0d", due.key_out, result.key_out);
                        errors++;
                    end
                    if (result.value_out !== due.value_out)
                    begin
                        $error("value_out: expected %0d, actual %0d",
                               due.value_out, result.value_out);
                        errors++;
                    end
                    if (result.history_length !== due.history_length)
                    begin
                        $error("history_length: expected %0d, actual %0d",
                               due.history_length, result.history_length);
                        errors++;
                    end
                end
            end
            if (start && !busy)
            begin
                kv_results_due.push_back(model_kv_command(item));
                commands_accepted++;
                item_taken = 1'b1;
            end
        end
    end

    // watchdog on cycles with no transfer in either direction
    always @(posedge clk)
    begin
        if ((start && !busy) || done)
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial
    begin
        // directed: extremes, gate limits, fill and pointer corner cases
        push_command(make_command(OP_READ, 0, 0, 0, 0, 0, 0, 0, 0), 1'b0);
        push_command(make_command(OP_WRITE, 0, 0, 127, 0, 32767, -32768, 256, 127), 1'b0);
        push_command(make_command(OP_WRITE, 7, 63, 0, 63, -32768, 32767, 256, 0), 1'b0);
        push_command(make_command(OP_WRITE, 0, 0, 0, 0, 100, -100, 0, 0), 1'b0);
        push_command(make_command(OP_WRITE, 0, 0, 0, 0, -1, 1, 511, 0), 1'b0);
        push_command(make_command(OP_WRITE, 0, 1, 0, 1, -3, 3, 128, 0), 1'b0);
        push_command(make_command(OP_WRITE, 0, 1, 0, 1, -32768, 32767, 255, 0), 1'b0);
        push_command(make_command(OP_ADVANCE, 0, 0, 0, 0, 0, 0, 0, 2), 1'b0);
        push_command(make_command(OP_READ, 0, 0, 0, 0, 0, 0, 0, 0), 1'b0);
        push_command(make_command(OP_READ, 0, 0, 1, 1, 0, 0, 0, 0), 1'b0);
        push_command(make_command(OP_READ, 0, 0, 2, 0, 0, 0, 0, 0), 1'b0);
        push_command(make_command(OP_READ, 0, 0, 127, 0, 0, 0, 0, 0), 1'b0);
        // oversized advance: pointer wraps, fill saturates
        push_command(make_command(OP_ADVANCE, 0, 0, 0, 0, 0, 0, 0, 127), 1'b0);
        push_command(make_command(OP_READ, 7, 0, 63, 63, 0, 0, 0, 0), 1'b0);
        push_command(make_command(OP_READ, 0, 0, 0, 0, 0, 0, 0, 0), 1'b0);
        // clear keeps data and pointer
        push_command(make_command(OP_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1);
        push_command(make_command(OP_READ, 0, 0, 0, 0, 0, 0, 0, 0), 1'b0);
        push_command(make_command(OP_ADVANCE, 0, 0, 0, 0, 0, 0, 0, 0), 1'b0);
        push_command(make_command(OP_ADVANCE, 0, 0, 0, 0, 0, 0, 0, 64), 1'b0);
        push_command(make_command(OP_READ, 0, 0, 0, 0, 0, 0, 0, 0), 1'b0);
        push_command(make_command(OP_WRITE, 5, 63, 127, 63, 4660, -4660, 256, 127), 1'b0);
        push_command(make_command(OP_READ, 5, 0, 0, 63, 0, 0, 0, 0), 1'b0);
        push_command(make_command(OP_READ, 5, 0, 63, 63, 0, 0, 0, 0), 1'b0);
        queue_random_commands(480);

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // head size settings: extremes, zero, beyond the store, random
        next_phase(7'd1, 76, 150);
        next_phase(7'd0, 76, 40);
        next_phase(7'd127, 76, 300);
        next_phase(7'($urandom_range(63, 2)), 0, 250);
        next_phase(7'd64, 0, 320);

        wait_until_drained();
        repeat (8) @(posedge clk);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
